>>> hw/rtl/burs_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// burs_pkg
// Shared types and constants of the bounded undo/redo stacks.
// ----------------------------------------------------------------------------
package burs_pkg;

	// fixed field widths of the request and response words
	localparam int SNAP_W = 32;
	localparam int CNT_W  = 7;

	// request codes
	typedef enum logic [1:0] {
		REQ_PUSH  = 2'd0,
		REQ_UNDO  = 2'd1,
		REQ_REDO  = 2'd2,
		REQ_CLEAR = 2'd3
	} req_type_t;

	// per-stack control for one word
	typedef struct packed {
		logic push;
		logic pop;
		logic clear;
	} stack_ctl_t;

endpackage : burs_pkg
`default_nettype wire

>>> hw/rtl/burs_req_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// burs_req_if
// Request channel: valid/ready handshake with request code and snapshot.
// ----------------------------------------------------------------------------
interface burs_req_if import burs_pkg::*;;
	logic              valid;
	logic              ready;
	req_type_t         req_type;
	logic [SNAP_W-1:0] snapshot_word;

	modport source (output valid, output req_type, output snapshot_word, input ready);
	modport sink   (input valid, input req_type, input snapshot_word, output ready);
endinterface : burs_req_if
`default_nettype wire

>>> hw/rtl/burs_rsp_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// burs_rsp_if
// Response channel: valid/ready handshake with status, word and counts.
// ----------------------------------------------------------------------------
interface burs_rsp_if import burs_pkg::*;;
	logic              valid;
	logic              ready;
	logic              ok;
	logic [SNAP_W-1:0] restored_word;
	logic [CNT_W-1:0]  undo_count;
	logic [CNT_W-1:0]  redo_count;

	modport source (
		output valid, output ok, output restored_word,
		output undo_count, output redo_count, input ready
	);
	modport sink (
		input valid, input ok, input restored_word,
		input undo_count, input redo_count, output ready
	);
endinterface : burs_rsp_if
`default_nettype wire

>>> hw/rtl/burs_stack.sv
`default_nettype none
// ----------------------------------------------------------------------------
// burs_stack
// One bounded stack: circular word memory with a top pointer and a
// saturating fill count. A push onto a full stack overwrites the oldest
// entry. The popped word appears on rdata in the cycle after the pop.
// ----------------------------------------------------------------------------
module burs_stack import burs_pkg::*; #(
	parameter  int DEPTH     = 64,
	parameter  int WORD_BITS = 32,
	localparam int AW        = $clog2(DEPTH),
	localparam int CW        = $clog2(DEPTH + 1)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire stack_ctl_t           ctl,
	input  wire logic [WORD_BITS-1:0] wdata,
	output logic      [WORD_BITS-1:0] rdata,
	output logic      [CW-1:0]        fill
);

	logic [WORD_BITS-1:0] mem [DEPTH];
	logic [WORD_BITS-1:0] rdata_q;
	logic [AW-1:0]        top_q;
	logic [CW-1:0]        fill_q;
	logic [AW-1:0]        top_inc;
	logic [AW-1:0]        top_dec;

	// wrapped neighbours of the top pointer
	assign top_inc = (top_q == AW'(DEPTH - 1)) ? '0 : top_q + AW'(1);
	assign top_dec = (top_q == '0) ? AW'(DEPTH - 1) : top_q - AW'(1);

	// pointer and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top_q  <= '0;
			fill_q <= '0;
		end else if (ctl.clear) begin
			top_q  <= '0;
			fill_q <= '0;
		end else if (ctl.push) begin
			top_q <= top_inc;
			if (fill_q != CW'(DEPTH)) begin
				fill_q <= fill_q + CW'(1);
			end
		end else if (ctl.pop) begin
			top_q <= top_dec;
			if (fill_q != '0) begin
				fill_q <= fill_q - CW'(1);
			end
		end
	end

	// word memory, registered read port
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[top_q] <= wdata;
		end
		if (ctl.pop) begin
			rdata_q <= mem[top_dec];
		end
	end

	assign rdata = rdata_q;
	assign fill  = fill_q;

endmodule : burs_stack
`default_nettype wire

>>> hw/rtl/bounded_undo_redo_stacks.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_undo_redo_stacks
// Undo and redo history of opaque snapshot words, DEPTH entries per stack.
// ----------------------------------------------------------------------------
// Takes one request word per cycle while the response side is not stalled,
// and returns one response word per request, through the registered read of
// the stack memory and then the output register. Push stores the snapshot on the
// undo stack and empties the redo stack; undo moves the given snapshot onto
// the redo stack and returns the undo top; redo is the mirror image; clear
// empties both. An undo or redo on an empty source stack changes nothing and
// answers ok low with a zero word. Every response carries both counts after
// the step. Stored words need no clearing after reset, so the block is ready
// from the first cycle out of reset.
// ----------------------------------------------------------------------------
module bounded_undo_redo_stacks import burs_pkg::*; #(
	parameter int DEPTH     = 64,
	parameter int WORD_BITS = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	burs_req_if.sink  req,
	burs_rsp_if.source rsp
);

	localparam int CW = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		SRC_NONE,
		SRC_UNDO,
		SRC_REDO
	} src_t;

	stack_ctl_t           undo_ctl;
	stack_ctl_t           redo_ctl;
	logic [WORD_BITS-1:0] undo_rdata;
	logic [WORD_BITS-1:0] redo_rdata;
	logic [CW-1:0]        undo_fill;
	logic [CW-1:0]        redo_fill;

	logic                 accept;
	logic                 advance;
	logic                 ok_d;
	src_t                 src_d;

	logic                 valid_s1;
	logic                 ok_s1;
	src_t                 src_s1;

	logic                 out_valid_q;
	logic                 out_ok_q;
	logic [SNAP_W-1:0]    out_word_q;
	logic [CNT_W-1:0]     out_undo_q;
	logic [CNT_W-1:0]     out_redo_q;

	logic [WORD_BITS+SNAP_W-1:0] snap_ext;
	logic [WORD_BITS-1:0]        wword;
	logic [WORD_BITS-1:0]        rword;
	logic [WORD_BITS+SNAP_W-1:0] rword_ext;
	logic [CW+CNT_W-1:0]         undo_cnt_ext;
	logic [CW+CNT_W-1:0]         redo_cnt_ext;

	// handshake
	assign advance   = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;
	assign accept    = req.valid && req.ready;

	// keep the low WORD_BITS of the snapshot
	assign snap_ext = {{WORD_BITS{1'b0}}, req.snapshot_word};
	assign wword    = snap_ext[WORD_BITS-1:0];

	// request decode into stack controls
	always_comb begin
		undo_ctl = '0;
		redo_ctl = '0;
		ok_d     = 1'b1;
		src_d    = SRC_NONE;
		case (req.req_type)
			REQ_PUSH: begin
				undo_ctl.push  = accept;
				redo_ctl.clear = accept;
			end
			REQ_UNDO: begin
				if (undo_fill == '0) begin
					ok_d = 1'b0;
				end else begin
					redo_ctl.push = accept;
					undo_ctl.pop  = accept;
					src_d         = SRC_UNDO;
				end
			end
			REQ_REDO: begin
				if (redo_fill == '0) begin
					ok_d = 1'b0;
				end else begin
					undo_ctl.push = accept;
					redo_ctl.pop  = accept;
					src_d         = SRC_REDO;
				end
			end
			REQ_CLEAR: begin
				undo_ctl.clear = accept;
				redo_ctl.clear = accept;
			end
			default: begin
				ok_d = 1'b0;
			end
		endcase
	end

	burs_stack #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_undo (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (undo_ctl),
		.wdata  (wword),
		.rdata  (undo_rdata),
		.fill   (undo_fill)
	);

	burs_stack #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_redo (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (redo_ctl),
		.wdata  (wword),
		.rdata  (redo_rdata),
		.fill   (redo_fill)
	);

	// stage 1: waits for the memory read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			ok_s1    <= 1'b0;
			src_s1   <= SRC_NONE;
		end else if (accept) begin
			valid_s1 <= 1'b1;
			ok_s1    <= ok_d;
			src_s1   <= src_d;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// popped word select and width fitting
	always_comb begin
		case (src_s1)
			SRC_UNDO: rword = undo_rdata;
			SRC_REDO: rword = redo_rdata;
			default:  rword = '0;
		endcase
	end

	assign rword_ext    = {{SNAP_W{1'b0}}, rword};
	assign undo_cnt_ext = {{CNT_W{1'b0}}, undo_fill};
	assign redo_cnt_ext = {{CNT_W{1'b0}}, redo_fill};

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_ok_q   <= ok_s1;
			out_word_q <= rword_ext[SNAP_W-1:0];
			out_undo_q <= undo_cnt_ext[CNT_W-1:0];
			out_redo_q <= redo_cnt_ext[CNT_W-1:0];
		end
	end

	assign rsp.valid         = out_valid_q;
	assign rsp.ok            = out_ok_q;
	assign rsp.restored_word = out_word_q;
	assign rsp.undo_count    = out_undo_q;
	assign rsp.redo_count    = out_redo_q;

`ifndef SYNTHESIS
	// fill counts saturate at the depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(undo_fill <= CW'(DEPTH)) && (redo_fill <= CW'(DEPTH)))
		else $error("stack fill count above depth");

	// a failed undo or redo returns a zero word
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && !rsp.ok |-> rsp.restored_word == '0)
		else $error("failed request returned a non-zero word");

	// a push leaves the redo stack empty
	a_push_redo: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.req_type == REQ_PUSH |=> redo_fill == '0)
		else $error("redo stack not emptied by push");

	// clear empties both stacks
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.req_type == REQ_CLEAR |=> undo_fill == '0 && redo_fill == '0)
		else $error("stacks not emptied by clear");

	// stage 1 is never overwritten before it moves on
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		accept && valid_s1 |-> advance)
		else $error("stage 1 overwritten while stalled");
`endif

endmodule : bounded_undo_redo_stacks
`default_nettype wire
